// File: src/disjoint_set_union_engine_assert.svh
// Assertion macros for the disjoint-set union engine.
// The first form is disabled while reset is asserted; the second is checked at every edge.
`ifndef DISJOINT_SET_UNION_ENGINE_ASSERT_SVH
`define DISJOINT_SET_UNION_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DSU_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DSU_ASSERT(lbl, prop, msg)
`define DSU_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// File: src/dsu_pkg.sv
`timescale 1ns / 1ps
package dsu_pkg;

  localparam int unsigned IdxBits      = 10;
  localparam int unsigned SizeBits     = 11;
  localparam int unsigned CountBits    = 11;
  localparam int unsigned ActBits      = 2;
  localparam int unsigned NodesDefault = 1024;

  localparam logic [CountBits-1:0] CountReset = 11'd1024;

  localparam logic [ActBits-1:0] ActFind  = 2'd0;
  localparam logic [ActBits-1:0] ActTest  = 2'd1;
  localparam logic [ActBits-1:0] ActMerge = 2'd2;
  localparam logic [ActBits-1:0] ActNone  = 2'd3;

  typedef struct packed {
    logic [IdxBits-1:0] root;
    logic               joined;
    logic               err;
  } result_t;

endpackage

// File: src/dsu_ram.sv
`timescale 1ns / 1ps
module dsu_ram #(
  parameter int unsigned Depth = dsu_pkg::NodesDefault,
  parameter int unsigned Width = dsu_pkg::SizeBits,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  import dsu_pkg::*;

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/dsu_ctrl.sv
`timescale 1ns / 1ps
module dsu_ctrl #(
  parameter int unsigned NODES = dsu_pkg::NodesDefault,
  localparam int unsigned IdxW = $clog2(NODES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dsu_pkg::ActBits-1:0]    action_i,
  input  logic [dsu_pkg::IdxBits-1:0]    first_node_i,
  input  logic [dsu_pkg::IdxBits-1:0]    second_node_i,
  input  logic [dsu_pkg::CountBits-1:0]  node_count_i,
  output logic                           busy_o,
  output logic                           done_o,
  output dsu_pkg::result_t               result_o,
  output logic                           par_we_o,
  output logic [IdxW-1:0]                par_waddr_o,
  output logic [IdxW-1:0]                par_wdata_o,
  output logic [IdxW-1:0]                par_raddr_o,
  input  logic [IdxW-1:0]                par_rdata_i,
  output logic                           sz_we_o,
  output logic [IdxW-1:0]                sz_waddr_o,
  output logic [dsu_pkg::SizeBits-1:0]   sz_wdata_o,
  output logic [IdxW-1:0]                sz_raddr_o,
  input  logic [dsu_pkg::SizeBits-1:0]   sz_rdata_i
);
  import dsu_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_COMP  = 6'b001000,
    ST_SZA   = 6'b010000,
    ST_SZB   = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     clr_q, clr_d;
  logic                done_q, done_d;
  logic                second_q, second_d;
  logic [ActBits-1:0]  act_q, act_d;
  logic [IdxW-1:0]     a_q, a_d;
  logic [IdxW-1:0]     b_q, b_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  logic [IdxW-1:0]     root_q, root_d;
  logic [IdxW-1:0]     ra_q, ra_d;
  logic [IdxW-1:0]     rb_q, rb_d;
  logic [SizeBits-1:0] sa_q, sa_d;
  result_t             res_q, res_d;

  logic                a_err;
  logic                b_err;
  logic [IdxW-1:0]     start_node;
  logic [SizeBits:0]   size_sum;
  logic [SizeBits-1:0] size_sat;

  // An index is out of range if it reaches either the programmed count or the table depth.
  assign a_err = ({1'b0, first_node_i} >= node_count_i) || (32'(first_node_i) >= NODES);
  assign b_err = ({1'b0, second_node_i} >= node_count_i) || (32'(second_node_i) >= NODES);

  assign start_node = second_q ? b_q : a_q;
  assign size_sum   = {1'b0, sa_q} + {1'b0, sz_rdata_i};
  assign size_sat   = size_sum[SizeBits] ? {SizeBits{1'b1}} : size_sum[SizeBits-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    done_d      = 1'b0;
    second_d    = second_q;
    act_d       = act_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    root_d      = root_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    sa_d        = sa_q;
    res_d       = res_q;
    par_we_o    = 1'b0;
    par_waddr_o = cur_q;
    par_wdata_o = root_q;
    par_raddr_o = cur_q;
    sz_we_o     = 1'b0;
    sz_waddr_o  = ra_q;
    sz_wdata_o  = size_sat;
    sz_raddr_o  = ra_q;

    unique case (state_q)
      ST_CLEAR: begin
        par_we_o    = 1'b1;
        par_waddr_o = clr_q;
        par_wdata_o = clr_q;
        sz_we_o     = 1'b1;
        sz_waddr_o  = clr_q;
        sz_wdata_o  = SizeBits'(1);
        if (clr_q == IdxW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        par_raddr_o = IdxW'(first_node_i);
        if (start_i) begin
          priority if (action_i == ActNone) begin
            res_d  = '0;
            done_d = 1'b1;
          end else if (a_err || (action_i != ActFind && b_err)) begin
            res_d.root   = '0;
            res_d.joined = 1'b0;
            res_d.err    = 1'b1;
            done_d       = 1'b1;
          end else begin
            act_d    = action_i;
            a_d      = IdxW'(first_node_i);
            b_d      = IdxW'(second_node_i);
            cur_d    = IdxW'(first_node_i);
            second_d = 1'b0;
            state_d  = ST_WALK;
          end
        end
      end

      // The link of cur_q arrives this cycle; follow it straight away.
      ST_WALK: begin
        if (par_rdata_i == cur_q) begin
          root_d      = cur_q;
          cur_d       = start_node;
          par_raddr_o = start_node;
          state_d     = ST_COMP;
        end else begin
          cur_d       = par_rdata_i;
          par_raddr_o = par_rdata_i;
        end
      end

      // Second pass over the same path, pointing every node at the root. The read of the
      // next node and the write of the current one never address the same entry.
      ST_COMP: begin
        if (cur_q == root_q) begin
          if (!second_q) begin
            ra_d = root_q;
            if (act_q == ActFind) begin
              res_d.root   = IdxBits'(root_q);
              res_d.joined = 1'b0;
              res_d.err    = 1'b0;
              done_d       = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              second_d    = 1'b1;
              cur_d       = b_q;
              par_raddr_o = b_q;
              state_d     = ST_WALK;
            end
          end else begin
            priority if (ra_q == root_q) begin
              res_d.root   = IdxBits'(ra_q);
              res_d.joined = 1'b1;
              res_d.err    = 1'b0;
              done_d       = 1'b1;
              state_d      = ST_IDLE;
            end else if (act_q == ActTest) begin
              res_d.root   = IdxBits'(ra_q);
              res_d.joined = 1'b0;
              res_d.err    = 1'b0;
              done_d       = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              rb_d       = root_q;
              sz_raddr_o = ra_q;
              state_d    = ST_SZA;
            end
          end
        end else begin
          par_we_o    = 1'b1;
          par_waddr_o = cur_q;
          par_wdata_o = root_q;
          cur_d       = par_rdata_i;
          par_raddr_o = par_rdata_i;
        end
      end

      ST_SZA: begin
        sa_d       = sz_rdata_i;
        sz_raddr_o = rb_q;
        state_d    = ST_SZB;
      end

      // On equal sizes the root of the first node survives.
      ST_SZB: begin
        par_we_o     = 1'b1;
        sz_we_o      = 1'b1;
        res_d.joined = 1'b0;
        res_d.err    = 1'b0;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
        if (sz_rdata_i > sa_q) begin
          par_waddr_o = ra_q;
          par_wdata_o = rb_q;
          sz_waddr_o  = rb_q;
          res_d.root  = IdxBits'(rb_q);
        end else begin
          par_waddr_o = rb_q;
          par_wdata_o = ra_q;
          sz_waddr_o  = ra_q;
          res_d.root  = IdxBits'(ra_q);
        end
      end

      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      second_q <= 1'b0;
      act_q    <= ActFind;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      second_q <= second_d;
      act_q    <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    cur_q  <= cur_d;
    root_q <= root_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    sa_q   <= sa_d;
    res_q  <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: src/disjoint_set_union_engine.sv
`timescale 1ns / 1ps
// Disjoint-set union engine: union-find over NODES nodes with path compression and
// union by size.
// Requests: raise start_i with action_i, first_node_i and second_node_i; the transaction
// is taken at a rising edge where start_i is high and busy_o is low. busy_o stays high
// until the result has been issued, so one request is in flight at a time.
// Results: done_o is high for exactly one cycle with result_root_o, already_joined_o and
// index_error_o; the receiver cannot stall, so it must take the result in that cycle.
// Operation: a rejected index or an unused action answers in the cycle after acceptance.
// A find walks the path to the root with one read per link, then compresses it with one
// write per link. A test walks both nodes; a merge then takes the two root sizes in
// ST_SZA and ST_SZB, the link and size write-back landing in ST_SZB. The parent memory
// has a single read port, so the walk follows one link per cycle.
// Configuration: the user writes node_count via cfg_valid_i/cfg_ready_o/cfg_data_i only
// while no request is outstanding, unchecked by the block; cfg_ready_o is always high.
// Reset: node_count returns to 1024 and a clearing pass over all NODES entries sets every
// node to be its own root with size one; busy_o is high throughout.
`include "disjoint_set_union_engine_assert.svh"
module disjoint_set_union_engine #(
  parameter int unsigned NODES = dsu_pkg::NodesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dsu_pkg::ActBits-1:0]   action_i,
  input  logic [dsu_pkg::IdxBits-1:0]   first_node_i,
  input  logic [dsu_pkg::IdxBits-1:0]   second_node_i,
  output logic                          done_o,
  output logic [dsu_pkg::IdxBits-1:0]   result_root_o,
  output logic                          already_joined_o,
  output logic                          index_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dsu_pkg::CountBits-1:0] cfg_data_i
);
  import dsu_pkg::*;

  localparam int unsigned IdxW = $clog2(NODES);

  logic [CountBits-1:0] node_count_q;
  result_t              result;

  logic                 par_we;
  logic [IdxW-1:0]      par_waddr;
  logic [IdxW-1:0]      par_wdata;
  logic [IdxW-1:0]      par_raddr;
  logic [IdxW-1:0]      par_rdata;
  logic                 sz_we;
  logic [IdxW-1:0]      sz_waddr;
  logic [SizeBits-1:0]  sz_wdata;
  logic [IdxW-1:0]      sz_raddr;
  logic [SizeBits-1:0]  sz_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  dsu_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .action_i     (action_i),
    .first_node_i (first_node_i),
    .second_node_i(second_node_i),
    .node_count_i (node_count_q),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .result_o     (result),
    .par_we_o     (par_we),
    .par_waddr_o  (par_waddr),
    .par_wdata_o  (par_wdata),
    .par_raddr_o  (par_raddr),
    .par_rdata_i  (par_rdata),
    .sz_we_o      (sz_we),
    .sz_waddr_o   (sz_waddr),
    .sz_wdata_o   (sz_wdata),
    .sz_raddr_o   (sz_raddr),
    .sz_rdata_i   (sz_rdata)
  );

  dsu_ram #(
    .Depth(NODES),
    .Width(IdxW)
  ) u_parent_mem (
    .clk_i  (clk_i),
    .we_i   (par_we),
    .waddr_i(par_waddr),
    .wdata_i(par_wdata),
    .raddr_i(par_raddr),
    .rdata_o(par_rdata)
  );

  dsu_ram #(
    .Depth(NODES),
    .Width(SizeBits)
  ) u_size_mem (
    .clk_i  (clk_i),
    .we_i   (sz_we),
    .waddr_i(sz_waddr),
    .wdata_i(sz_wdata),
    .raddr_i(sz_raddr),
    .rdata_o(sz_rdata)
  );

  assign result_root_o    = result.root;
  assign already_joined_o = result.joined;
  assign index_error_o    = result.err;

  logic req_accept;
  logic first_oob;

  assign req_accept = start_i && !busy_o;
  assign first_oob  = ({1'b0, first_node_i} >= node_count_q) || (32'(first_node_i) >= NODES);

  `DSU_ASSERT_NORST(a_busy_in_reset, !rst_ni |-> busy_o, "engine not busy during reset")
  `DSU_ASSERT(a_unused_action, req_accept && action_i == ActNone |=> done_o && result_root_o == 0 && !already_joined_o && !index_error_o, "unused action did not answer zero")
  `DSU_ASSERT(a_range_reject, req_accept && action_i != ActNone && first_oob |=> done_o && index_error_o, "out-of-range node not rejected")
  `DSU_ASSERT(a_error_payload, done_o && index_error_o |-> result_root_o == 0 && !already_joined_o, "rejected request carries a payload")
  `DSU_ASSERT(a_root_in_table, done_o && !index_error_o |-> 32'(result_root_o) < NODES, "root outside the table")

endmodule
